[rtl/tspdp_pkg.sv]
package tspdp_pkg;

	localparam int MAX_NODES = 256;
	localparam int MAX_ARITY = 4;
	localparam int MAX_DEPTH = 9;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CNT_W  = $clog2(MAX_NODES + 1);
	localparam int LVL_W  = $clog2(MAX_DEPTH + 1);
	localparam int SLOT_W = $clog2(MAX_ARITY);
	localparam int KID_W  = $clog2(MAX_ARITY + 1);
	localparam int ND_W   = NODE_W + KID_W;
	localparam int TID_W  = $clog2(MAX_DEPTH * MAX_ARITY + 1);
	localparam int TBL_AW = TID_W + CNT_W;

	localparam int WEIGHT_W = 32;
	localparam int SUM_W    = 48;
	localparam int WORD_W   = 64;
	localparam int NWORDS   = (MAX_NODES + WORD_W - 1) / WORD_W;
	localparam int WCNT_W   = $clog2(NWORDS + 1);
	localparam int QUEUE_W  = NODE_W + CNT_W;

	localparam logic [TID_W-1:0] ROOT_TID = TID_W'(MAX_DEPTH * MAX_ARITY);

	typedef enum logic [1:0] {
		REG_ARITY      = 2'd0,
		REG_SPARSITY   = 2'd1,
		REG_NODE_COUNT = 2'd2,
		REG_SPARE      = 2'd3
	} reg_idx_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_TOO_MANY = 1'b1;

endpackage

[rtl/tspdp_ram.sv]
module tspdp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/tree_sparse_projection_dp.sv]
// Tree-sparse projection over a complete d-ary tree held in breadth-first order.
// Input channel (in_valid/in_stall): cmd 0 stores weight at the load pointer and
// advances it; cmd 1 runs the selection of a rooted subtree of sparsity nodes.
// Loads are taken while idle and may follow back to back.
// A run holds in_stall high until its last result has been taken. Its length
// is set by the knapsack on the 48-bit table RAM: the (budget, child share)
// pairs and the budget slots per child, the table entries cleared and shifted,
// summed over every subtree walked for every node popped from the budget queue,
// plus the popped nodes and the child slots examined.
// Output channel (out_valid/out_stall): ceil(n/64) support words, n = node_count
// clamped to 2..256, last set on the final one; if sparsity exceeds n, a single
// word with status 1. A stalled word is held. Every run clears the load pointer.
// Configuration goes through the APB port (pready always high) while idle, which
// the block does not enforce. Reset clears the control state and load pointer;
// arity 2, sparsity 1, node_count 256. Weight and table RAMs are not cleared.
module tree_sparse_projection_dp import tspdp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd,
	input  logic signed [WEIGHT_W-1:0] weight,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 word_index,
	output logic [WORD_W-1:0]          support_bits,
	output logic                       status,
	output logic                       last
);

	typedef enum logic [4:0] {
		S_IDLE, S_Q_POP, S_Q_GOT, S_F_ENTER, S_F_LEAF, S_F_LEAF2, S_F_CHILD,
		S_F_CLEAR, S_F_JSTART, S_F_CUR, S_F_BEST, S_F_RA, S_F_RB, S_F_CMP,
		S_F_WCUR, S_F_SHIFT0, S_F_SH_R, S_F_SH_W, S_F_RET, S_A_INIT, S_A_RD,
		S_A_USE, S_OUT_WAIT
	} state_t;

	state_t state_q;

	logic [2:0]       arity_q;
	logic [8:0]       sparsity_q;
	logic [8:0]       node_count_q;

	logic [KID_W-1:0] run_d;
	logic [CNT_W-1:0] run_n;
	logic [CNT_W-1:0] run_k;
	logic [WCNT_W-1:0] words;

	logic [NODE_W-1:0] node_q  [MAX_DEPTH+1];
	logic [SLOT_W-1:0] slot_q  [MAX_DEPTH+1];
	logic [KID_W-1:0]  jj_q    [MAX_DEPTH+1];
	logic [CNT_W-1:0]  total_q [MAX_DEPTH+1];
	logic [MAX_ARITY-1:0][CNT_W-1:0] sz_q [MAX_DEPTH+1];

	logic [LVL_W-1:0]  lvl_q;
	logic [KID_W-1:0]  dj_q;
	logic [CNT_W-1:0]  ta_q;
	logic [CNT_W-1:0]  r_q;
	logic [CNT_W-1:0]  prev_q;
	logic [CNT_W-1:0]  maxn_q;
	logic [CNT_W-1:0]  cur_q;
	logic [CNT_W-1:0]  in_q;
	logic signed [SUM_W-1:0] best_q;
	logic signed [SUM_W-1:0] a_q;
	logic signed [WEIGHT_W-1:0] wt_q;
	logic [CNT_W-1:0]  ret_q;
	logic [CNT_W-1:0]  head_q;
	logic [CNT_W-1:0]  tail_q;
	logic [CNT_W-1:0]  bq_q;
	logic [NODE_W-1:0] ci_q;
	logic [SLOT_W-1:0] aj_q;
	logic [NODE_W-1:0] lp_q;
	logic [WCNT_W-1:0] wsel_q;
	logic [NWORDS-1:0][WORD_W-1:0] sup_q;

	logic              out_valid_q;
	logic [1:0]        word_index_q;
	logic [WORD_W-1:0] support_bits_q;
	logic              status_q;
	logic              last_q;

	// memories
	logic                 w_we;
	logic [NODE_W-1:0]    w_raddr;
	logic [WEIGHT_W-1:0]  w_rdata;
	logic                 t_we;
	logic [TBL_AW-1:0]    t_waddr, t_raddr;
	logic [SUM_W-1:0]     t_wdata, t_rdata;
	logic [MAX_ARITY-1:0] al_we;
	logic [NODE_W-1:0]    al_waddr, al_raddr;
	logic [CNT_W-1:0]     al_wdata;
	logic [CNT_W-1:0]     al_rdata [MAX_ARITY];
	logic                 q_we;
	logic [NODE_W-1:0]    q_waddr, q_raddr;
	logic [QUEUE_W-1:0]   q_wdata, q_rdata;

	// datapath helpers
	logic [NODE_W-1:0] lvl_node;
	logic [ND_W-1:0]   nd, child, q_nd, ci_full, n_last;
	logic              is_leaf;
	logic [TID_W-1:0]  own_tid, kid_tid;
	logic [CNT_W-1:0]  szj, ta_new, k_m1, new_max;
	logic [CNT_W:0]    m_sum;
	logic [NODE_W-1:0] q_node;
	logic [CNT_W-1:0]  q_bud;
	logic [CNT_W-1:0]  a_sel, a_cl;
	logic signed [SUM_W-1:0] cand;
	logic signed [SUM_W-1:0] w_ext, wt_ext;
	logic [LVL_W-1:0]  lvl_up, lvl_dn;
	logic              cfg_wr, in_xfer, out_xfer;
	logic [9:0]        n_round;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;

	assign out_valid    = out_valid_q;
	assign word_index   = word_index_q;
	assign support_bits = support_bits_q;
	assign status       = status_q;
	assign last         = last_q;

	always_comb begin
		prdata = '0;
		unique case (reg_idx_t'(paddr[3:2]))
			REG_ARITY:      prdata = 32'(arity_q);
			REG_SPARSITY:   prdata = 32'(sparsity_q);
			REG_NODE_COUNT: prdata = 32'(node_count_q);
			default:        prdata = '0;
		endcase
	end

	always_comb begin
		if (arity_q < 3'd2) begin
			run_d = KID_W'(2);
		end else if (32'(arity_q) > MAX_ARITY) begin
			run_d = KID_W'(MAX_ARITY);
		end else begin
			run_d = KID_W'(arity_q);
		end
		if (node_count_q < 9'd2) begin
			run_n = CNT_W'(2);
		end else if (32'(node_count_q) > MAX_NODES) begin
			run_n = CNT_W'(MAX_NODES);
		end else begin
			run_n = CNT_W'(node_count_q);
		end
		run_k   = CNT_W'(sparsity_q);
		n_round = 10'(run_n) + 10'(WORD_W - 1);
		words   = WCNT_W'(n_round >> $clog2(WORD_W));
	end

	always_comb begin
		lvl_up   = lvl_q + LVL_W'(1);
		lvl_dn   = lvl_q - LVL_W'(1);
		lvl_node = node_q[lvl_q];
		nd       = ND_W'(lvl_node) * ND_W'(run_d);
		child    = nd + ND_W'(jj_q[lvl_q]) + ND_W'(1);
		is_leaf  = (nd + ND_W'(1) >= ND_W'(run_n)) || (32'(lvl_q) >= MAX_DEPTH);
		if (lvl_q == '0) begin
			own_tid = ROOT_TID;
		end else begin
			own_tid = TID_W'(32'(lvl_dn) * MAX_ARITY + 32'(slot_q[lvl_q]));
		end
		kid_tid = TID_W'(32'(lvl_q) * MAX_ARITY + 32'(dj_q[SLOT_W-1:0]));
		szj     = sz_q[lvl_q][dj_q[SLOT_W-1:0]];
		ta_new  = (total_q[lvl_q] < run_k) ? total_q[lvl_q] : run_k;
		k_m1    = run_k - CNT_W'(1);
		m_sum   = {1'b0, maxn_q} + {1'b0, szj};
		new_max = (m_sum > {1'b0, k_m1}) ? k_m1 : m_sum[CNT_W-1:0];
		q_node  = q_rdata[QUEUE_W-1 -: NODE_W];
		q_bud   = q_rdata[CNT_W-1:0];
		q_nd    = ND_W'(q_node) * ND_W'(run_d);
		n_last  = ND_W'(run_n) - ND_W'(1);
		ci_full = nd + ND_W'(run_d);
		if (ci_full > n_last) begin
			ci_full = n_last;
		end
		a_sel   = al_rdata[aj_q];
		a_cl    = (a_sel > bq_q) ? bq_q : a_sel;
		cand    = ((in_q == '0) ? best_q : a_q) + $signed(t_rdata);
		w_ext   = {{(SUM_W-WEIGHT_W){w_rdata[WEIGHT_W-1]}}, w_rdata};
		wt_ext  = {{(SUM_W-WEIGHT_W){wt_q[WEIGHT_W-1]}}, wt_q};
	end

	// memory port control
	always_comb begin
		w_we     = in_xfer && (cmd == CMD_LOAD);
		w_raddr  = lvl_node;
		t_we     = 1'b0;
		t_waddr  = '0;
		t_wdata  = '0;
		t_raddr  = '0;
		al_we    = '0;
		al_waddr = cur_q[NODE_W-1:0];
		al_wdata = in_q;
		al_raddr = bq_q[NODE_W-1:0];
		q_we     = 1'b0;
		q_waddr  = tail_q[NODE_W-1:0];
		q_wdata  = {ci_q, a_cl};
		q_raddr  = head_q[NODE_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_xfer && (cmd == CMD_RUN) && (run_k <= run_n) && (run_k != '0)) begin
					q_we    = 1'b1;
					q_waddr = '0;
					q_wdata = {NODE_W'(0), run_k};
				end
			end
			S_F_LEAF: begin
				t_we    = 1'b1;
				t_waddr = {own_tid, CNT_W'(1)};
				t_wdata = w_ext;
			end
			S_F_LEAF2: begin
				t_we    = 1'b1;
				t_waddr = {own_tid, CNT_W'(0)};
			end
			S_F_CLEAR: begin
				if (r_q < ta_q) begin
					t_we     = 1'b1;
					t_waddr  = {own_tid, r_q};
					al_waddr = r_q[NODE_W-1:0];
					al_wdata = '0;
					if (lvl_q == '0) begin
						al_we = '1;
					end
				end
			end
			S_F_CUR:  t_raddr = {own_tid, cur_q};
			S_F_RA:   t_raddr = {own_tid, cur_q - in_q};
			S_F_RB:   t_raddr = {kid_tid, in_q};
			S_F_CMP: begin
				if ((best_q < cand) && (lvl_q == '0)) begin
					al_we[dj_q[SLOT_W-1:0]] = 1'b1;
				end
			end
			S_F_WCUR: begin
				t_we    = 1'b1;
				t_waddr = {own_tid, cur_q};
				t_wdata = best_q;
			end
			S_F_SH_R: t_raddr = {own_tid, r_q - CNT_W'(1)};
			S_F_SH_W: begin
				t_we    = 1'b1;
				t_waddr = {own_tid, r_q};
				t_wdata = $signed(t_rdata) + wt_ext;
			end
			S_A_USE: begin
				if ((a_cl != '0) && (32'(tail_q) < MAX_NODES)) begin
					q_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	tspdp_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_NODES)) u_weight_ram (
		.clk(clk), .we(w_we), .waddr(lp_q), .wdata(weight),
		.raddr(w_raddr), .rdata(w_rdata)
	);

	tspdp_ram #(.WIDTH(SUM_W), .DEPTH(2 ** TBL_AW)) u_table_ram (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	tspdp_ram #(.WIDTH(QUEUE_W), .DEPTH(MAX_NODES)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(q_raddr), .rdata(q_rdata)
	);

	for (genvar g = 0; g < MAX_ARITY; g++) begin : g_alloc
		tspdp_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_alloc_ram (
			.clk(clk), .we(al_we[g]), .waddr(al_waddr), .wdata(al_wdata),
			.raddr(al_raddr), .rdata(al_rdata[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			arity_q      <= 3'd2;
			sparsity_q   <= 9'd1;
			node_count_q <= 9'd256;
			lp_q         <= '0;
			lvl_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			wsel_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (reg_idx_t'(paddr[3:2]))
					REG_ARITY:      arity_q      <= pwdata[2:0];
					REG_SPARSITY:   sparsity_q   <= pwdata[8:0];
					REG_NODE_COUNT: node_count_q <= pwdata[8:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (cmd == CMD_LOAD) begin
							lp_q <= lp_q + NODE_W'(1);
						end else begin
							lp_q <= '0;
							if (run_k > run_n) begin
								out_valid_q    <= 1'b1;
								word_index_q   <= '0;
								support_bits_q <= '0;
								status_q       <= STATUS_TOO_MANY;
								last_q         <= 1'b1;
								state_q        <= S_OUT_WAIT;
							end else begin
								sup_q   <= '0;
								head_q  <= '0;
								tail_q  <= (run_k != '0) ? CNT_W'(1) : '0;
								state_q <= S_Q_POP;
							end
						end
					end
				end
				S_Q_POP: begin
					if (head_q < tail_q) begin
						state_q <= S_Q_GOT;
					end else begin
						wsel_q         <= '0;
						out_valid_q    <= 1'b1;
						word_index_q   <= '0;
						support_bits_q <= sup_q[0];
						status_q       <= STATUS_OK;
						last_q         <= (words == WCNT_W'(1));
						state_q        <= S_OUT_WAIT;
					end
				end
				S_Q_GOT: begin
					sup_q[q_node[NODE_W-1:6]][q_node[5:0]] <= 1'b1;
					head_q <= head_q + CNT_W'(1);
					bq_q   <= q_bud - CNT_W'(1);
					if (q_nd + ND_W'(1) >= ND_W'(run_n)) begin
						state_q <= S_Q_POP;
					end else begin
						node_q[0] <= q_node;
						lvl_q     <= '0;
						state_q   <= S_F_ENTER;
					end
				end
				S_F_ENTER: begin
					if (is_leaf) begin
						state_q <= S_F_LEAF;
					end else begin
						jj_q[lvl_q]    <= '0;
						total_q[lvl_q] <= CNT_W'(1);
						state_q        <= S_F_CHILD;
					end
				end
				S_F_LEAF:  state_q <= S_F_LEAF2;
				S_F_LEAF2: begin
					ret_q   <= CNT_W'(1);
					state_q <= S_F_RET;
				end
				S_F_CHILD: begin
					if ((jj_q[lvl_q] < run_d) && (child < ND_W'(run_n))) begin
						node_q[lvl_up] <= child[NODE_W-1:0];
						slot_q[lvl_up] <= jj_q[lvl_q][SLOT_W-1:0];
						lvl_q          <= lvl_up;
						state_q        <= S_F_ENTER;
					end else begin
						ta_q    <= ta_new;
						r_q     <= '0;
						state_q <= S_F_CLEAR;
					end
				end
				S_F_CLEAR: begin
					if (r_q < ta_q) begin
						r_q <= r_q + CNT_W'(1);
					end else begin
						dj_q    <= '0;
						maxn_q  <= '0;
						state_q <= S_F_JSTART;
					end
				end
				S_F_JSTART: begin
					if (dj_q < jj_q[lvl_q]) begin
						prev_q  <= maxn_q;
						maxn_q  <= new_max;
						cur_q   <= new_max;
						state_q <= S_F_CUR;
					end else begin
						r_q     <= ta_q;
						state_q <= S_F_SHIFT0;
					end
				end
				S_F_CUR: begin
					in_q    <= (szj < cur_q) ? szj : cur_q;
					state_q <= S_F_BEST;
				end
				S_F_BEST: begin
					best_q  <= $signed(t_rdata);
					state_q <= S_F_RA;
				end
				S_F_RA: state_q <= S_F_RB;
				S_F_RB: begin
					a_q     <= $signed(t_rdata);
					state_q <= S_F_CMP;
				end
				S_F_CMP: begin
					if (best_q < cand) begin
						best_q <= cand;
					end
					if ((in_q == '0) || (cur_q - in_q >= prev_q)) begin
						state_q <= S_F_WCUR;
					end else begin
						in_q    <= in_q - CNT_W'(1);
						state_q <= S_F_RA;
					end
				end
				S_F_WCUR: begin
					if (cur_q <= CNT_W'(1)) begin
						dj_q    <= dj_q + KID_W'(1);
						state_q <= S_F_JSTART;
					end else begin
						cur_q   <= cur_q - CNT_W'(1);
						state_q <= S_F_CUR;
					end
				end
				S_F_SHIFT0: begin
					wt_q    <= $signed(w_rdata);
					state_q <= S_F_SH_R;
				end
				S_F_SH_R: begin
					if (r_q != '0) begin
						state_q <= S_F_SH_W;
					end else begin
						ret_q   <= ta_q;
						state_q <= S_F_RET;
					end
				end
				S_F_SH_W: begin
					r_q     <= r_q - CNT_W'(1);
					state_q <= S_F_SH_R;
				end
				S_F_RET: begin
					if (lvl_q == '0) begin
						state_q <= S_A_INIT;
					end else begin
						sz_q[lvl_dn][jj_q[lvl_dn][SLOT_W-1:0]] <= ret_q;
						total_q[lvl_dn] <= total_q[lvl_dn] + ret_q;
						jj_q[lvl_dn]    <= jj_q[lvl_dn] + KID_W'(1);
						lvl_q           <= lvl_dn;
						state_q         <= S_F_CHILD;
					end
				end
				S_A_INIT: begin
					ci_q    <= ci_full[NODE_W-1:0];
					aj_q    <= SLOT_W'(ci_full - nd - ND_W'(1));
					state_q <= S_A_RD;
				end
				S_A_RD: state_q <= S_A_USE;
				S_A_USE: begin
					if ((a_cl != '0) && (32'(tail_q) < MAX_NODES)) begin
						tail_q <= tail_q + CNT_W'(1);
						bq_q   <= bq_q - a_cl;
					end
					if (aj_q == '0) begin
						state_q <= S_Q_POP;
					end else begin
						ci_q    <= ci_q - NODE_W'(1);
						aj_q    <= aj_q - SLOT_W'(1);
						state_q <= S_A_RD;
					end
				end
				S_OUT_WAIT: begin
					if (out_xfer) begin
						if (last_q) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							wsel_q         <= wsel_q + WCNT_W'(1);
							word_index_q   <= 2'(wsel_q + WCNT_W'(1));
							support_bits_q <= sup_q[2'(wsel_q + WCNT_W'(1))];
							status_q       <= STATUS_OK;
							last_q         <= (wsel_q + WCNT_W'(2) == words);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[tb/tree_sparse_projection_dp_checker.sv]
`timescale 1ns / 1ps

module tree_sparse_projection_dp_checker import tspdp_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [3:0]                 paddr,
	input  logic [31:0]                pwdata,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       cmd,
	input  logic signed [WEIGHT_W-1:0] weight,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [1:0]                 word_index,
	input  logic [WORD_W-1:0]          support_bits,
	input  logic                       status,
	input  logic                       last,
	output int                         errors,
	output int                         pending
);

	typedef struct packed {
		logic [1:0]        idx;
		logic [WORD_W-1:0] bits;
		logic              st;
		logic              lst;
	} support_word_t;

	localparam int NTBL = MAX_DEPTH * MAX_ARITY + 1;

	support_word_t support_q[$];
	logic signed [WEIGHT_W-1:0] weights[MAX_NODES];
	int unsigned load_ptr, cfg_arity, cfg_k, cfg_n;
	int unsigned run_d, run_n, run_k, top_parent;
	longint best[NTBL][MAX_NODES+1];
	int unsigned share[MAX_NODES+1][MAX_ARITY];
	bit chosen[MAX_NODES];
	int unsigned bq_node[MAX_NODES];
	int unsigned bq_budget[MAX_NODES];

	initial begin
		errors = 0;
		pending = 0;
		for (int i = 0; i < MAX_NODES; i++) weights[i] = '0;
		for (int t = 0; t < NTBL; t++)
			for (int i = 0; i <= MAX_NODES; i++) best[t][i] = 0;
		for (int i = 0; i <= MAX_NODES; i++)
			for (int j = 0; j < MAX_ARITY; j++) share[i][j] = 0;
	end

	function automatic longint node_wt(int unsigned nd);
		return (nd >= MAX_NODES) ? 64'sd0 : longint'(weights[nd]);
	endfunction

	// best gain of a rooted subtree at nd for each budget, into table tid
	function automatic int unsigned subtree_gain(int unsigned nd, int unsigned lvl,
			int unsigned tid);
		int unsigned sz[MAX_ARITY];
		int unsigned total, kids, slots, maxn, prv, cur, cnt, c, ctid, r;
		longint cand;
		total = 1;
		kids = 0;
		maxn = 0;
		if (nd > top_parent || lvl >= MAX_DEPTH) begin
			best[tid][0] = 0;
			best[tid][1] = node_wt(nd);
			return 1;
		end
		for (int j = 0; j < run_d; j++) begin
			c = nd * run_d + 1 + j;
			if (c >= run_n) break;
			sz[j] = subtree_gain(c, lvl + 1, lvl * MAX_ARITY + j);
			total += sz[j];
			kids++;
		end
		slots = (total < run_k) ? total : run_k;
		for (r = 0; r < slots; r++) begin
			best[tid][r] = 0;
			for (int j = 0; j < MAX_ARITY; j++) share[r][j] = 0;
		end
		for (int j = 0; j < kids; j++) begin
			ctid = lvl * MAX_ARITY + j;
			prv = maxn;
			maxn = maxn + sz[j];
			if (maxn > run_k - 1) maxn = run_k - 1;
			cur = maxn;
			forever begin
				cnt = (sz[j] < cur) ? sz[j] : cur;
				forever begin
					cand = best[tid][cur-cnt] + best[ctid][cnt];
					if (best[tid][cur] < cand) begin
						best[tid][cur] = cand;
						share[cur][j] = cnt;
					end
					if (cnt == 0) break;
					if (cur - cnt >= prv) break;
					cnt--;
				end
				if (cur <= 1) break;
				cur--;
			end
		end
		for (r = slots; r >= 1; r--) best[tid][r] = best[tid][r-1] + node_wt(nd);
		return slots;
	endfunction

	task automatic predict_run();
		int unsigned head, tail, nd, b, ci, j, a, nw, dummy;
		support_word_t sw;
		head = 0;
		tail = 0;
		load_ptr = 0;
		run_d = (cfg_arity < 2) ? 2 : ((cfg_arity > MAX_ARITY) ? MAX_ARITY : cfg_arity);
		run_n = (cfg_n < 2) ? 2 : ((cfg_n > MAX_NODES) ? MAX_NODES : cfg_n);
		run_k = cfg_k;
		if (run_k > run_n) begin
			sw = '{idx: 2'd0, bits: '0, st: STATUS_TOO_MANY, lst: 1'b1};
			support_q.push_back(sw);
			return;
		end
		top_parent = (run_n - 2) / run_d;
		for (int i = 0; i < MAX_NODES; i++) chosen[i] = 1'b0;
		if (run_k > 0) begin
			bq_node[0] = 0;
			bq_budget[0] = run_k;
			tail = 1;
		end
		while (head < tail) begin
			nd = bq_node[head];
			b = bq_budget[head];
			head++;
			chosen[nd] = 1'b1;
			b -= 1;
			if (nd > top_parent) continue;
			dummy = subtree_gain(nd, 0, NTBL - 1);
			ci = nd * run_d + run_d;
			if (ci > run_n - 1) ci = run_n - 1;
			j = ci - nd * run_d - 1;
			forever begin
				a = (b <= MAX_NODES && j < MAX_ARITY) ? share[b][j] : 0;
				if (a > b) a = b;
				if (a > 0 && tail < MAX_NODES) begin
					bq_node[tail] = ci;
					bq_budget[tail] = a;
					tail++;
					b -= a;
				end
				if (j == 0) break;
				j--;
				ci--;
			end
		end
		nw = (run_n + 63) / 64;
		for (int w = 0; w < nw; w++) begin
			sw.idx = 2'(w);
			sw.bits = '0;
			for (int i = 0; i < 64; i++)
				if (w * 64 + i < run_n && chosen[w*64+i]) sw.bits[i] = 1'b1;
			sw.st = STATUS_OK;
			sw.lst = (w + 1 == nw);
			support_q.push_back(sw);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		support_word_t exp_w;
		if (!arst_n) begin
			load_ptr = 0;
			cfg_arity = 2;
			cfg_k = 1;
			cfg_n = 256;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_ARITY:      cfg_arity = pwdata & 32'h7;
					REG_SPARSITY:   cfg_k = pwdata & 32'h1FF;
					REG_NODE_COUNT: cfg_n = pwdata & 32'h1FF;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_LOAD) begin
					weights[load_ptr % MAX_NODES] = weight;
					load_ptr = (load_ptr + 1) % MAX_NODES;
				end else begin
					predict_run();
				end
			end
			if (out_valid && !out_stall) begin
				if (support_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected transfer: idx %0d bits %h status %0d last %0d",
							word_index, support_bits, status, last);
				end else begin
					exp_w = support_q.pop_front();
					if (word_index !== exp_w.idx || support_bits !== exp_w.bits ||
							status !== exp_w.st || last !== exp_w.lst) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp idx %0d bits %h st %0d last %0d, %s",
								exp_w.idx, exp_w.bits, exp_w.st, exp_w.lst,
								$sformatf("got idx %0d bits %h st %0d last %0d",
									word_index, support_bits, status, last));
					end
				end
			end
			pending = support_q.size();
		end
	end

endmodule

[tb/tree_sparse_projection_dp_tb.sv]
`timescale 1ns / 1ps

module tree_sparse_projection_dp_tb;
	import tspdp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic cmd = CMD_LOAD;
	logic signed [WEIGHT_W-1:0] weight = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] word_index;
	logic [WORD_W-1:0] support_bits;
	logic status, last;
	int errors, pending;
	int mode = 0;
	int hold_req = 0;

	tree_sparse_projection_dp i_dut (.*);

	tree_sparse_projection_dp_checker i_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#1_000_000_000;
		$display("tree_sparse_projection_dp_tb: FAIL");
		$finish;
	end

	function automatic bit roll(int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic logic [31:0] rand_wt();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			4, 5: return $urandom_range(0, 32'h0004_0000) - 32'h0001_0000;
			default: return $urandom;
		endcase
	endfunction

	// receiver
	always @(negedge clk) begin
		int hold;
		if (hold_req != 0) begin
			hold = hold_req;
			hold_req = 0;
		end
		if (hold > 0) begin
			hold--;
			out_stall = 1'b1;
		end else begin
			out_stall = (mode == 2) ? roll(47) : (mode == 3) ? roll(10) : 1'b0;
		end
	end

	task automatic apb_write(reg_idx_t r, logic [31:0] v);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {r, 2'b00};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send(logic c, logic [31:0] w);
		while ((mode == 1 && roll(47)) || (mode == 3 && roll(10))) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd = c;
		weight = w;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic configure(int unsigned a, int unsigned k, int unsigned n);
		drain();
		apb_write(REG_ARITY, a);
		apb_write(REG_SPARSITY, k);
		apb_write(REG_NODE_COUNT, n);
	endtask

	initial begin
		int unsigned n, k, m, cnt;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// fill every weight once, extremes first
		send(CMD_LOAD, 32'h7FFF_FFFF);
		send(CMD_LOAD, 32'h8000_0000);
		send(CMD_LOAD, 32'h0);
		send(CMD_LOAD, 32'hFFFF_FFFF);
		for (int i = 4; i < MAX_NODES; i++) send(CMD_LOAD, rand_wt());
		send(CMD_RUN, '0);
		configure(2, 0, 2);
		send(CMD_RUN, '0);
		configure(3, 511, 256);
		send(CMD_RUN, '0);
		configure(4, 256, 255);
		send(CMD_RUN, '0);
		configure(4, 32, 256);
		send(CMD_RUN, '0);
		configure(2, 2, 2);
		send(CMD_RUN, '0);
		configure(0, 3, 0);
		send(CMD_RUN, '0);
		configure(7, 5, 7);
		send(CMD_RUN, '0);
		configure(1, 4, 300);
		send(CMD_RUN, '0);
		for (int ph = 0; ph < 8; ph++) begin
			n = roll(15) ? $urandom_range(65, 140) : $urandom_range(2, 40);
			k = roll(15) ? $urandom_range(0, 511) : $urandom_range(0, (n < 12) ? n + 1 : 12);
			configure(roll(15) ? $urandom_range(0, 7) : $urandom_range(2, 4), k, n);
			mode = ph % 4;
			if (ph == 2) begin
				hold_req = 400;
				send(CMD_RUN, '0);
				for (int i = 0; i < 30; i++) send(CMD_LOAD, rand_wt());
			end
			if (ph == 5) begin
				send(CMD_RUN, '0);
				drain();
			end
			cnt = 0;
			while (cnt < 8) begin
				m = roll(20) ? $urandom_range(0, 3) : $urandom_range(0, (n < 8) ? n : 8);
				for (int i = 0; i < m; i++) send(CMD_LOAD, rand_wt());
				send(CMD_RUN, '0);
				cnt += m + 1;
			end
		end
		mode = 0;
		drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("tree_sparse_projection_dp_tb: PASS");
		else
			$display("tree_sparse_projection_dp_tb: FAIL");
		$finish;
	end

endmodule
